// ===== rtl/core/dwma_pkg.sv =====
// ----------------------------------------------------------------------------
// dwma_pkg
// Shared constants, state encoding and control bundles for the dual-window
// moving average.
// ----------------------------------------------------------------------------
package dwma_pkg;

   // Sizes of the history ring and the averaging windows
   localparam int HISTORY_DEPTH = 60;
   localparam int SHORT_WINDOW  = 10;
   localparam int SAMPLE_BITS   = 16;
   localparam int HELD_BITS     = 6;

   // Derived widths
   localparam int IDX_BITS  = $clog2(HISTORY_DEPTH);
   localparam int CNT_BITS  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   // Controller states
   typedef enum logic [2:0] {
      ST_ARM,
      ST_IDLE,
      ST_WALK,
      ST_DIV_S,
      ST_WAIT_S,
      ST_DIV_L,
      ST_WAIT_L,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store;       // write the accepted sample, step pointers, clear walk
      logic walk;        // read and accumulate history entries
      logic div_start;   // launch the divider
      logic div_long;    // divider operands: long window (else short window)
      logic take_short;  // capture quotient as short average
      logic take_long;   // capture quotient as long average
      logic load_rsp;    // move the averages into the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic walk_done;   // all held entries accumulated
      logic div_done;    // divider quotient ready
      logic long_needed; // more samples held than the short window
      logic rsp_free;    // result register can take a new transaction
   } status_type;

endpackage

// ===== rtl/core/dwma_if.sv =====
// ----------------------------------------------------------------------------
// dwma_if
// Valid/ready channels for samples and averaged results.
// ----------------------------------------------------------------------------
interface dwma_req_if;
   logic                               valid;
   logic                               ready;
   logic [dwma_pkg::SAMPLE_BITS-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dwma_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dwma_pkg::SAMPLE_BITS-1:0]   avg_short;
   logic [dwma_pkg::SAMPLE_BITS-1:0]   avg_long;
   logic [dwma_pkg::HELD_BITS-1:0]     samples_held;

   modport source (output valid, output avg_short, output avg_long,
                   output samples_held, input ready);
   modport sink   (input valid, input avg_short, input avg_long,
                   input samples_held, output ready);
endinterface

// ===== rtl/core/dwma_div.sv =====
// ----------------------------------------------------------------------------
// dwma_div
// Restoring divider, one quotient bit per cycle. Divides the window sum by
// the window sample count.
// ----------------------------------------------------------------------------
module dwma_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dwma_pkg::SUM_BITS-1:0]   dividend,
   input  logic [dwma_pkg::CNT_BITS-1:0]   divisor,
   output logic                            done,
   output logic [dwma_pkg::SUM_BITS-1:0]   quotient
);

   logic [dwma_pkg::SUM_BITS-1:0]   quo_ff, quo_in;
   logic [dwma_pkg::CNT_BITS-1:0]   rem_ff, rem_in;
   logic [dwma_pkg::CNT_BITS-1:0]   dvs_ff, dvs_in;
   logic [dwma_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                            done_ff, done_in;
   logic [dwma_pkg::CNT_BITS:0]     partial;
   logic [dwma_pkg::CNT_BITS:0]     diff;
   logic                            fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      partial = {rem_ff, quo_ff[dwma_pkg::SUM_BITS-1]};
      diff    = partial - {1'b0, dvs_ff};
      fits    = (partial >= {1'b0, dvs_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      done_in = done_ff;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = dwma_pkg::STEP_BITS'(dwma_pkg::SUM_BITS);
         done_in = 1'b0;
      end else if (step_ff != '0) begin
         quo_in  = {quo_ff[dwma_pkg::SUM_BITS-2:0], fits};
         rem_in  = fits ? diff[dwma_pkg::CNT_BITS-1:0] : partial[dwma_pkg::CNT_BITS-1:0];
         step_in = step_ff - dwma_pkg::STEP_BITS'(1);
         done_in = (step_ff == dwma_pkg::STEP_BITS'(1));
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/dwma_datapath.sv =====
// ----------------------------------------------------------------------------
// dwma_datapath
// History ring memory, write and read pointers, window accumulator, shared
// divider and the result register.
// ----------------------------------------------------------------------------
module dwma_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  dwma_pkg::cmd_type                  cmd,
   output dwma_pkg::status_type               status,
   input  logic [dwma_pkg::SAMPLE_BITS-1:0]   sample,
   dwma_rsp_if.source                         rsp_chan
);

   localparam logic [dwma_pkg::IDX_BITS-1:0] LAST_IDX =
      dwma_pkg::IDX_BITS'(dwma_pkg::HISTORY_DEPTH - 1);
   localparam logic [dwma_pkg::CNT_BITS-1:0] FULL_CNT =
      dwma_pkg::CNT_BITS'(dwma_pkg::HISTORY_DEPTH);
   localparam logic [dwma_pkg::CNT_BITS-1:0] SHORT_CNT =
      dwma_pkg::CNT_BITS'(dwma_pkg::SHORT_WINDOW);

   // History ring
   logic [dwma_pkg::SAMPLE_BITS-1:0]  history_mem [dwma_pkg::HISTORY_DEPTH];
   logic [dwma_pkg::SAMPLE_BITS-1:0]  rd_data_ff;

   // Pointers and counters
   logic [dwma_pkg::IDX_BITS-1:0]     wr_pos_ff, wr_pos_in;
   logic [dwma_pkg::CNT_BITS-1:0]     held_ff, held_in;
   logic [dwma_pkg::IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic [dwma_pkg::CNT_BITS-1:0]     issue_cnt_ff, issue_cnt_in;
   logic [dwma_pkg::CNT_BITS-1:0]     acc_cnt_ff, acc_cnt_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic                              rd_en;

   // Sums and averages
   logic [dwma_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic [dwma_pkg::SUM_BITS-1:0]     short_sum_ff, short_sum_in;
   logic [dwma_pkg::SUM_BITS-1:0]     sum_next;
   logic [dwma_pkg::SAMPLE_BITS-1:0]  avg_s_ff, avg_s_in;
   logic [dwma_pkg::SAMPLE_BITS-1:0]  avg_l_ff, avg_l_in;
   logic [dwma_pkg::CNT_BITS-1:0]     short_n;

   // Result register
   logic                              rsp_vld_ff, rsp_vld_in;
   logic [dwma_pkg::SAMPLE_BITS-1:0]  rsp_avg_s_ff, rsp_avg_s_in;
   logic [dwma_pkg::SAMPLE_BITS-1:0]  rsp_avg_l_ff, rsp_avg_l_in;
   logic [dwma_pkg::HELD_BITS-1:0]    rsp_held_ff, rsp_held_in;

   // Divider hookup
   logic [dwma_pkg::SUM_BITS-1:0]     div_dividend;
   logic [dwma_pkg::CNT_BITS-1:0]     div_divisor;
   logic                              div_done;
   logic [dwma_pkg::SUM_BITS-1:0]     div_quotient;

   assign short_n  = (held_ff < SHORT_CNT) ? held_ff : SHORT_CNT;
   assign sum_next = sum_ff + dwma_pkg::SUM_BITS'(rd_data_ff);
   assign rd_en    = cmd.walk && (issue_cnt_ff != held_ff);

   // Pointer, counter and accumulator updates
   always_comb begin
      wr_pos_in    = wr_pos_ff;
      held_in      = held_ff;
      rd_idx_in    = rd_idx_ff;
      issue_cnt_in = issue_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      rd_vld_in    = 1'b0;
      sum_in       = sum_ff;
      short_sum_in = short_sum_ff;

      if (cmd.store) begin
         // ring fills downward; newest entry sits at the write pointer
         wr_pos_in    = (wr_pos_ff == '0) ? LAST_IDX : wr_pos_ff - dwma_pkg::IDX_BITS'(1);
         held_in      = (held_ff < FULL_CNT) ? held_ff + dwma_pkg::CNT_BITS'(1) : held_ff;
         rd_idx_in    = wr_pos_in;
         issue_cnt_in = '0;
         acc_cnt_in   = '0;
         sum_in       = '0;
      end else if (cmd.walk) begin
         // issue reads newest to oldest, wrapping at the top of the ring
         if (rd_en) begin
            rd_vld_in    = 1'b1;
            rd_idx_in    = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + dwma_pkg::IDX_BITS'(1);
            issue_cnt_in = issue_cnt_ff + dwma_pkg::CNT_BITS'(1);
         end
         // accumulate data returned by the memory
         if (rd_vld_ff) begin
            sum_in     = sum_next;
            acc_cnt_in = acc_cnt_ff + dwma_pkg::CNT_BITS'(1);
            if (acc_cnt_in == short_n) begin
               short_sum_in = sum_next;
            end
         end
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         history_mem[wr_pos_in] <= sample;
      end
      if (rd_en) begin
         rd_data_ff <= history_mem[rd_idx_ff];
      end
   end

   // Divider operands
   assign div_dividend = cmd.div_long ? sum_ff : short_sum_ff;
   assign div_divisor  = cmd.div_long ? held_ff : short_n;

   dwma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Average capture and result register
   always_comb begin
      avg_s_in     = cmd.take_short ? div_quotient[dwma_pkg::SAMPLE_BITS-1:0] : avg_s_ff;
      avg_l_in     = cmd.take_long  ? div_quotient[dwma_pkg::SAMPLE_BITS-1:0] : avg_l_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_avg_s_in = rsp_avg_s_ff;
      rsp_avg_l_in = rsp_avg_l_ff;
      rsp_held_in  = rsp_held_ff;
      if (cmd.load_rsp) begin
         rsp_vld_in   = 1'b1;
         rsp_avg_s_in = avg_s_ff;
         rsp_avg_l_in = avg_l_ff;
         rsp_held_in  = dwma_pkg::HELD_BITS'(held_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         held_ff      <= '0;
         issue_cnt_ff <= '0;
         acc_cnt_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         held_ff      <= held_in;
         issue_cnt_ff <= issue_cnt_in;
         acc_cnt_ff   <= acc_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      sum_ff       <= sum_in;
      short_sum_ff <= short_sum_in;
      avg_s_ff     <= avg_s_in;
      avg_l_ff     <= avg_l_in;
      rsp_avg_s_ff <= rsp_avg_s_in;
      rsp_avg_l_ff <= rsp_avg_l_in;
      rsp_held_ff  <= rsp_held_in;
   end

   // Status back to the controller
   assign status.walk_done   = (acc_cnt_ff == held_ff);
   assign status.div_done    = div_done;
   assign status.long_needed = (held_ff > short_n);
   assign status.rsp_free    = !rsp_vld_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.avg_short    = rsp_avg_s_ff;
   assign rsp_chan.avg_long     = rsp_avg_l_ff;
   assign rsp_chan.samples_held = rsp_held_ff;

endmodule

// ===== rtl/core/dwma_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwma_ctrl
// Sequencer: arms on the first sample, then per sample stores, walks the ring,
// runs the short and (if over ten are held) long division, hands off the result.
// ----------------------------------------------------------------------------
module dwma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dwma_pkg::status_type   status,
   output dwma_pkg::cmd_type      cmd
);

   dwma_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwma_pkg::ST_ARM;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;

      case (state_ff)
         dwma_pkg::ST_ARM: begin
            // first transaction only arms the block
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = dwma_pkg::ST_IDLE;
            end
         end
         dwma_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               state_in  = dwma_pkg::ST_WALK;
            end
         end
         dwma_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = dwma_pkg::ST_DIV_S;
            end
         end
         dwma_pkg::ST_DIV_S: begin
            cmd.div_start = 1'b1;
            state_in      = dwma_pkg::ST_WAIT_S;
         end
         dwma_pkg::ST_WAIT_S: begin
            if (status.div_done) begin
               cmd.take_short = 1'b1;
               if (status.long_needed) begin
                  state_in = dwma_pkg::ST_DIV_L;
               end else begin
                  // both windows cover the same samples
                  cmd.take_long = 1'b1;
                  state_in      = dwma_pkg::ST_OUT;
               end
            end
         end
         dwma_pkg::ST_DIV_L: begin
            cmd.div_start = 1'b1;
            cmd.div_long  = 1'b1;
            state_in      = dwma_pkg::ST_WAIT_L;
         end
         dwma_pkg::ST_WAIT_L: begin
            if (status.div_done) begin
               cmd.take_long = 1'b1;
               state_in      = dwma_pkg::ST_OUT;
            end
         end
         dwma_pkg::ST_OUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = dwma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dwma_pkg::ST_ARM;
         end
      endcase
   end

endmodule

// ===== rtl/core/dual_window_moving_average.sv =====
// ----------------------------------------------------------------------------
// dual_window_moving_average
// Short and long truncated moving averages of a Q0.16 utilization stream.
// ----------------------------------------------------------------------------
// The first sample after reset only arms the block and yields no result.
// Every later sample goes into a 60-entry history ring and yields one
// result: the mean of the newest min(10, held) samples, the mean of the
// newest min(60, held) samples, and the number held (1..60). One sample is
// processed at a time. For each sample the block accepts it, walks the
// single-port history memory at one entry per cycle through its registered
// read, runs two passes of a bit-per-cycle 22-bit divider, short window
// then long, and loads the output register. While ten or fewer samples are
// held the second division is skipped. A new sample is accepted while the
// previous result still waits in the output register; the next result then
// waits until that one is taken.
// ----------------------------------------------------------------------------
module dual_window_moving_average (
   input  logic         clock,
   input  logic         reset,
   dwma_req_if.sink     req_chan,
   dwma_rsp_if.source   rsp_chan
);

   dwma_pkg::cmd_type      cmd;
   dwma_pkg::status_type   status;

   // Sequencer
   dwma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Ring, accumulator, divider and result register
   dwma_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .sample   (req_chan.sample),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/dwma_average_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dwma_average_checker
// Watches the sample and result channels of the dual-window moving average,
// keeps its own copy of the history ring, and compares every result
// transaction with the predicted averages, oldest first.
// ----------------------------------------------------------------------------
module dwma_average_checker
   import dwma_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dwma_req_if    req_mon,
   dwma_rsp_if    rsp_mon,
   output int     mismatch_count,
   output int     averages_waiting
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] avg_short;
      logic [SAMPLE_BITS-1:0] avg_long;
      logic [HELD_BITS-1:0]   samples_held;
   } average_result_type;

   // Predicted state of the block
   logic [SAMPLE_BITS-1:0] ring [HISTORY_DEPTH];
   int unsigned            newest_pos;
   int unsigned            held_total;
   logic                   armed;

   average_result_type     pending_averages [$];

   assign averages_waiting = pending_averages.size();

   // Store one sample as the newest entry and work out both means
   function automatic average_result_type fold_in_sample(input logic [SAMPLE_BITS-1:0] value);
      average_result_type result;
      int unsigned        short_n;
      int unsigned        short_sum;
      int unsigned        long_sum;
      int unsigned        pos;
      int unsigned        k;
      // ring fills downwards, older entries at rising indices
      newest_pos = (newest_pos == 0) ? HISTORY_DEPTH - 1 : newest_pos - 1;
      ring[newest_pos] = value;
      if (held_total < HISTORY_DEPTH)
         held_total++;
      short_n = (held_total < SHORT_WINDOW) ? held_total : SHORT_WINDOW;
      short_sum = 0;
      long_sum = 0;
      pos = newest_pos;
      for (k = 0; k < held_total; k++) begin
         if (k < short_n)
            short_sum += ring[pos];
         long_sum += ring[pos];
         pos = (pos + 1 == HISTORY_DEPTH) ? 0 : pos + 1;
      end
      result.avg_short    = SAMPLE_BITS'(short_sum / short_n);
      result.avg_long     = SAMPLE_BITS'(long_sum / held_total);
      result.samples_held = HELD_BITS'(held_total);
      return result;
   endfunction

   // Compare results first, then predict from the sample taken at this edge
   always @(posedge clock) begin
      average_result_type want;
      if (reset) begin
         newest_pos = 0;
         held_total = 0;
         armed = 1'b0;
         pending_averages.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_averages.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result short=%0d long=%0d held=%0d", $realtime,
                           rsp_mon.avg_short, rsp_mon.avg_long, rsp_mon.samples_held);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_averages.pop_front();
               if (rsp_mon.avg_short !== want.avg_short ||
                   rsp_mon.avg_long !== want.avg_long ||
                   rsp_mon.samples_held !== want.samples_held) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch expected short=%0d long=%0d held=%0d, got short=%0d long=%0d held=%0d",
                              $realtime, want.avg_short, want.avg_long, want.samples_held,
                              rsp_mon.avg_short, rsp_mon.avg_long, rsp_mon.samples_held);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            // the first sample after reset only arms the block
            if (!armed)
               armed = 1'b1;
            else
               pending_averages.push_back(fold_in_sample(req_mon.sample));
         end
      end
   end

   initial mismatch_count = 0;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dual-window moving average: a directed run of
// edge values, then random sample streams with idle gaps on the sample side
// and stalls on the result side, including one long result hold-off.
// ----------------------------------------------------------------------------
module tb;
   import dwma_pkg::*;

   typedef enum int {
      PAT_UNIFORM,
      PAT_HIGH,
      PAT_LOW,
      PAT_ONEHOT,
      PAT_FULL,
      PAT_ZERO
   } pattern_type;

   localparam int RANDOM_SAMPLES = 1430;
   localparam int HOLD_OFF_AFTER = 300;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   averages_waiting;
   int   samples_sent;
   logic quiet_phase;
   logic hold_off_done;

   dwma_req_if req_chan ();
   dwma_rsp_if rsp_chan ();

   dual_window_moving_average dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dwma_average_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatch_count   (mismatch_count),
      .averages_waiting (averages_waiting)
   );

   // Clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Edge values; the first one is dropped by the block
   logic [SAMPLE_BITS-1:0] directed_samples [20] = '{
      16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE,
      16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h00FF, 16'hFF00
   };

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(input int min_len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(min_len, 3);
      else if (roll < 92)
         return $urandom_range(4, 120);
      else
         return $urandom_range(121, 400);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input pattern_type pat);
      case (pat)
         PAT_HIGH:   return 16'hFFFF - 16'($urandom_range(0, 255));
         PAT_LOW:    return 16'($urandom_range(0, 255));
         PAT_ONEHOT: return 16'h0001 << $urandom_range(0, SAMPLE_BITS - 1);
         PAT_FULL:   return 16'hFFFF;
         PAT_ZERO:   return 16'h0000;
         default:    return 16'($urandom());
      endcase
   endfunction

   // One sample transaction, then an optional idle gap
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input int gap);
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      samples_sent++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Reset and stimulus
   initial begin
      pattern_type pat;
      int          run_len;
      int          sent_random;
      int          k;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      samples_sent = 0;
      quiet_phase = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_samples[i])
         send_sample(directed_samples[i], (i % 4 == 3) ? pick_gap(0) : 0);

      // random segments of one pattern each, some without any idling
      sent_random = 0;
      while (sent_random < RANDOM_SAMPLES) begin
         pat = pattern_type'($urandom_range(0, 9) < 5 ? PAT_UNIFORM : $urandom_range(1, 5));
         run_len = $urandom_range(1, 90);
         quiet_phase = ($urandom_range(0, 4) == 0);
         for (k = 0; k < run_len && sent_random < RANDOM_SAMPLES; k++) begin
            send_sample(pick_sample(pat), quiet_phase ? 0 : pick_gap(0));
            sent_random++;
         end
      end
      req_chan.valid <= 1'b0;
      quiet_phase = 1'b0;

      // drain, then allow for any stray late result
      @(posedge clock);
      while (averages_waiting != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, one long hold-off, always ready when quiet
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_off_done = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_off_done && samples_sent >= HOLD_OFF_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else if (quiet_phase) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (pick_gap(1)) @(posedge clock);
         end
      end
   end

   // Run limit
   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
